[hdl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg: shared types and codes of the interpolation table
// operation codes, status codes, widths and the command passed to the back end
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DATA_W    = 32;
    localparam int TOL_SHIFT = 20;

    // operation codes on the input tuser
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_BELOW  = 3'd2;
    localparam logic [2:0] ST_ABOVE  = 3'd3;
    localparam logic [2:0] ST_FLAT   = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;
    localparam logic [2:0] ST_EMPTY  = 3'd6;

    // decoded command, one flag per kind, none set for a no-op
    typedef struct packed {
        logic                     do_clear;
        logic                     do_append;
        logic                     do_query;
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] sample_value;
    } cmd_t;

endpackage

[hdl/piecewise_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with linear interpolation
// clear, append and query on signed Q16.16 breakpoints, one result per item
// ----------------------------------------------------------------------------
// Each input transfer carries an opcode in s_tuser (clear, append, query or
// no-op) and a position and a sample value in s_tdata; each produces exactly
// one result transfer with a value in m_tdata and a status in m_tuser. Inputs
// go into a two-entry queue, so up to two items are taken while the back end
// is busy or a result waits on m_tready. Clear, append, no-op and the queries
// that end early (empty table, below the first point, single entry) are
// answered from the idle state without a search. A query at or above the
// first point scans the stored positions from entry one at one entry per
// cycle until it finds the first one greater than the query, or else ends
// as above the table at the last entry; a segment that is flat against the
// span tolerance ends there, otherwise a multiply state, a divider load state
// and the bit-serial divider follow. Table contents have no reset and need
// none: only entries written since the last clear are ever used.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import pli_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*DATA_W-1:0] s_tdata,   // position [31:0], sample_value [63:32]
    input  logic [1:0]          s_tuser,   // opcode [1:0]
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // result_value [31:0]
    output logic [2:0]          m_tuser    // status [2:0]
);

    // decoded command between the queue and the back end
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // front end: decode each transfer and queue it
    pli_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // back end: table storage, search and interpolation, registered result
    pli_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata),
        .out_status (m_tuser)
    );

endmodule

[hdl/pli_front.sv]
// ----------------------------------------------------------------------------
// pli_front: input front end
// decodes each input transfer and holds it in a two-entry queue
// ----------------------------------------------------------------------------
module pli_front import pli_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2*DATA_W-1:0] s_tdata,   // position, sample_value
    input  logic [1:0]        s_tuser,     // opcode
    output cmd_t              cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);

    cmd_t       decoded;
    cmd_t       queue_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    always_comb begin
        decoded              = '0;
        decoded.position     = s_tdata[DATA_W-1:0];
        decoded.sample_value = s_tdata[2*DATA_W-1:DATA_W];
        case (s_tuser)
            OP_CLEAR:  decoded.do_clear  = 1'b1;
            OP_APPEND: decoded.do_append = 1'b1;
            OP_QUERY:  decoded.do_query  = 1'b1;
            default: begin
            end
        endcase
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

[hdl/pli_div.sv]
// ----------------------------------------------------------------------------
// pli_div: iterative unsigned divider
// restoring division, one quotient bit per cycle; numerator high half < divisor
// ----------------------------------------------------------------------------
module pli_div import pli_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [2*DATA_W-1:0] num,
    input  logic [DATA_W-1:0]   den,
    output logic                done,
    output logic [DATA_W-1:0]   quot
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num[2*DATA_W-1:DATA_W];
                quo_reg  <= num[DATA_W-1:0];
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/pli_core.sv]
// ----------------------------------------------------------------------------
// pli_core: table back end
// breakpoint memories, linear search, offset multiply and rounded division
// ----------------------------------------------------------------------------
module pli_core import pli_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_result,
    output logic [2:0]        out_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;

    logic [2:0]               state_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            idx_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        result_reg;
    logic [2:0]               status_reg;

    logic signed [DATA_W-1:0] pos_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] pos_rd_reg;
    logic signed [DATA_W-1:0] val_rd_reg;

    logic signed [DATA_W-1:0] pos0_reg;
    logic signed [DATA_W-1:0] val0_reg;
    logic signed [DATA_W-1:0] last_pos_reg;
    logic signed [DATA_W-1:0] last_val_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] prev_pos_reg;
    logic signed [DATA_W-1:0] prev_val_reg;

    logic [DATA_W-1:0]        off_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic [DATA_W-1:0]        dx_reg;
    logic [DATA_W-1:0]        y0_reg;
    logic                     neg_reg;
    logic [2*DATA_W-1:0]      prod_reg;

    logic                     take;
    logic                     full;
    logic                     scan_start;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic                     found;
    logic                     last_idx;
    logic signed [DATA_W:0]   dx_w;
    logic signed [DATA_W:0]   span_w;
    logic [DATA_W:0]          span_abs;
    logic [DATA_W:0]          tol;
    logic                     flat;
    logic signed [DATA_W:0]   dy_w;
    logic [DATA_W:0]          mag_w;
    logic signed [DATA_W:0]   off_w;
    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quot;
    logic [2*DATA_W-1:0]      div_num;

    assign cmd_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign take       = cmd_valid && cmd_ready;
    assign full       = (count_reg == CW'(TABLE_DEPTH));
    assign wr_en      = take && cmd.do_append && !full;
    assign wr_addr    = count_reg[AW-1:0];
    assign rd_addr    = (state_reg == S_SCAN) ? idx_reg + AW'(1) : AW'(1);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign out_status = status_reg;

    // query at or above the first position in a table of two or more entries
    assign scan_start = take && cmd.do_query && (count_reg > CW'(1))
                      && !(cmd.position < pos0_reg);

    // one write and one registered read per memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_mem[wr_addr] <= cmd.position;
            val_mem[wr_addr] <= cmd.sample_value;
        end
        pos_rd_reg <= pos_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    // segment checks on the entry just read
    always_comb begin
        found    = (pos_rd_reg > q_reg);
        last_idx = ((CW'(idx_reg) + CW'(1)) >= count_reg);
        dx_w     = {pos_rd_reg[DATA_W-1], pos_rd_reg}
                 - {prev_pos_reg[DATA_W-1], prev_pos_reg};
        span_w   = {last_pos_reg[DATA_W-1], last_pos_reg}
                 - {pos0_reg[DATA_W-1], pos0_reg};
        span_abs = span_w[DATA_W] ? $unsigned(-span_w) : $unsigned(span_w);
        tol      = span_abs >> TOL_SHIFT;
        flat     = dx_w[DATA_W] || (dx_w == '0) || ($unsigned(dx_w) < tol);
        dy_w     = {val_rd_reg[DATA_W-1], val_rd_reg}
                 - {prev_val_reg[DATA_W-1], prev_val_reg};
        mag_w    = dy_w[DATA_W] ? $unsigned(-dy_w) : $unsigned(dy_w);
        off_w    = {q_reg[DATA_W-1], q_reg}
                 - {prev_pos_reg[DATA_W-1], prev_pos_reg};
    end

    // rounding to nearest: add half the divisor
    assign div_start = (state_reg == S_DIVS);
    assign div_num   = prod_reg + {{(DATA_W + 1){1'b0}}, dx_reg[DATA_W-1:1]};

    pli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dx_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        out_valid_reg <= !scan_start;
                        if (cmd.do_clear) begin
                            count_reg  <= '0;
                            result_reg <= '0;
                            status_reg <= ST_DONE;
                        end else if (cmd.do_append) begin
                            result_reg <= '0;
                            if (full) begin
                                status_reg <= ST_FULL;
                            end else begin
                                status_reg   <= ST_DONE;
                                count_reg    <= count_reg + CW'(1);
                                last_pos_reg <= cmd.position;
                                last_val_reg <= cmd.sample_value;
                                if (count_reg == '0) begin
                                    pos0_reg <= cmd.position;
                                    val0_reg <= cmd.sample_value;
                                end
                            end
                        end else if (cmd.do_query) begin
                            if (count_reg == '0) begin
                                status_reg <= ST_EMPTY;
                                result_reg <= '0;
                            end else if (cmd.position < pos0_reg) begin
                                status_reg <= ST_BELOW;
                                result_reg <= val0_reg;
                            end else if (count_reg == CW'(1)) begin
                                status_reg <= ST_ABOVE;
                                result_reg <= last_val_reg;
                            end else begin
                                // entry one is being read this cycle
                                q_reg         <= cmd.position;
                                prev_pos_reg  <= pos0_reg;
                                prev_val_reg  <= val0_reg;
                                idx_reg       <= AW'(1);
                                state_reg     <= S_SCAN;
                            end
                        end else begin
                            result_reg <= '0;
                            status_reg <= ST_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        if (flat) begin
                            out_valid_reg <= 1'b1;
                            result_reg    <= prev_val_reg;
                            status_reg    <= ST_FLAT;
                            state_reg     <= S_IDLE;
                        end else begin
                            off_reg   <= off_w[DATA_W-1:0];
                            mag_reg   <= mag_w[DATA_W-1:0];
                            dx_reg    <= dx_w[DATA_W-1:0];
                            y0_reg    <= prev_val_reg;
                            neg_reg   <= dy_w[DATA_W];
                            state_reg <= S_MUL;
                        end
                    end else if (last_idx) begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= last_val_reg;
                        status_reg    <= ST_ABOVE;
                        state_reg     <= S_IDLE;
                    end else begin
                        prev_pos_reg <= pos_rd_reg;
                        prev_val_reg <= val_rd_reg;
                        idx_reg      <= idx_reg + AW'(1);
                    end
                end
                S_MUL: begin
                    prod_reg  <= off_reg * mag_reg;
                    state_reg <= S_DIVS;
                end
                S_DIVS: begin
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= neg_reg ? y0_reg - div_quot : y0_reg + div_quot;
                        status_reg    <= ST_INTERP;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (count_reg >= CW'(2)))
        else $error("search running on fewer than two entries");

    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("search index past the stored entries");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIVW))
        else $error("divider finished outside its wait state");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while an item is in progress");
`endif

endmodule
